// File: hw/rtl/lrd_pkg.sv
// Package for the log record deframer: result codes, header constants
// and the queue word passed from the front to the back. No dependencies.
`default_nettype none
package lrd_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam logic [3:0]  HDR_LAST     = 4'(HEADER_BYTES - 1);
    localparam logic [31:0] CRC32C_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] MARKER_RESET = 32'hFFFF_FFFF;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [1:0] VERD_GOOD     = 2'd0;
    localparam logic [1:0] VERD_MISMATCH = 2'd1;
    localparam logic [1:0] VERD_CLEAN    = 2'd2;
    localparam logic [1:0] VERD_TRUNC    = 2'd3;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [1:0]  verdict;
        logic        deletion;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic        two;
        logic [1:0]  second_verdict;
    } t_entry;

endpackage
`default_nettype wire

// File: hw/rtl/lrd_if.sv
// Stream interfaces of the log record deframer: byte input and result output.
// Depends on nothing.
`default_nettype none
interface lrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface lrd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [1:0]  verdict;
    logic        deletion;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        last;

    modport source (output valid, output out_byte, output out_kind, output verdict,
                    output deletion, output key_length, output value_length,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input out_kind, input verdict,
                    input deletion, input key_length, input value_length,
                    input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lrd_front.sv
// Front of the deframer: header parse, CRC32C update, record classification.
// Pushes one queue word per byte that causes results. Uses lrd_pkg.
`default_nettype none
module lrd_front import lrd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output      logic        o_push,
    output      t_entry      o_entry
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [31:0] r_stored, n_stored;
    logic [31:0] r_key, n_key;
    logic [31:0] r_value, n_value;
    logic [32:0] r_left, n_left;
    logic [31:0] r_crc, n_crc;
    logic        r_del, n_del;
    logic        r_halted, n_halted;
    logic [31:0] r_marker;

    logic [31:0] crc_next;
    logic [31:0] val_word;
    logic [31:0] eff_value;
    logic        is_del;
    logic [32:0] total;
    logic [32:0] left_dec;
    logic        good;
    logic        restart;
    logic [4:0]  sel;

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_stored = r_stored;
        n_key    = r_key;
        n_value  = r_value;
        n_left   = r_left;
        n_crc    = r_crc;
        n_del    = r_del;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_entry  = '0;
        restart  = 1'b0;

        crc_next  = crc_byte(r_crc, i_data_byte);
        good      = ((crc_next ^ CRC_INIT) == r_stored);
        sel       = {r_hcnt[1:0], 3'b000};
        val_word  = {i_data_byte, r_value[23:0]};
        is_del    = (val_word == r_marker);
        eff_value = is_del ? 32'd0 : val_word;
        total     = {1'b0, r_key} + {1'b0, eff_value};
        left_dec  = r_left - 33'd1;

        if (i_accept && !r_halted) begin
            if (i_end_of_file) begin
                o_push          = 1'b1;
                o_entry.kind    = KIND_END;
                o_entry.verdict = (r_phase == PH_HEADER && r_hcnt == 4'd0)
                                  ? VERD_CLEAN : VERD_TRUNC;
                n_halted        = 1'b1;
            end else if (r_phase == PH_HEADER) begin
                n_hcnt = r_hcnt + 4'd1;
                case (r_hcnt[3:2])
                    2'd0: n_stored[sel +: 8] = i_data_byte;
                    2'd1: begin
                        n_key[sel +: 8] = i_data_byte;
                        n_crc           = crc_next;
                    end
                    default: begin
                        n_value[sel +: 8] = i_data_byte;
                        n_crc             = crc_next;
                    end
                endcase
                if (r_hcnt == HDR_LAST) begin
                    n_del   = is_del;
                    n_value = eff_value;
                    n_left  = total;
                    n_phase = PH_PAYLOAD;
                    if (total == 33'd0) begin
                        o_push               = 1'b1;
                        o_entry.kind         = KIND_VERDICT;
                        o_entry.verdict      = good ? VERD_GOOD : VERD_MISMATCH;
                        o_entry.deletion     = is_del;
                        o_entry.key_length   = r_key;
                        o_entry.value_length = eff_value;
                        restart              = good;
                        n_halted             = !good;
                    end
                end
            end else begin
                n_crc                = crc_next;
                n_left               = left_dec;
                o_push               = 1'b1;
                o_entry.data         = i_data_byte;
                o_entry.kind         = (r_left > {1'b0, r_value}) ? KIND_KEY : KIND_VALUE;
                o_entry.verdict      = VERD_GOOD;
                o_entry.deletion     = r_del;
                o_entry.key_length   = r_key;
                o_entry.value_length = r_value;
                if (left_dec == 33'd0) begin
                    o_entry.two            = 1'b1;
                    o_entry.second_verdict = good ? VERD_GOOD : VERD_MISMATCH;
                    restart                = good;
                    n_halted               = !good;
                end
            end
        end

        if (restart) begin
            n_phase  = PH_HEADER;
            n_hcnt   = 4'd0;
            n_stored = 32'd0;
            n_key    = 32'd0;
            n_value  = 32'd0;
            n_left   = 33'd0;
            n_crc    = CRC_INIT;
            n_del    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcnt   <= 4'd0;
            r_stored <= 32'd0;
            r_key    <= 32'd0;
            r_value  <= 32'd0;
            r_left   <= 33'd0;
            r_crc    <= CRC_INIT;
            r_del    <= 1'b0;
            r_halted <= 1'b0;
            r_marker <= MARKER_RESET;
        end else begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_stored <= n_stored;
            r_key    <= n_key;
            r_value  <= n_value;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_del    <= n_del;
            r_halted <= n_halted;
            if (i_cfg_we) begin
                r_marker <= i_cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lrd_queue.sv
// Short queue between the front and the back of the deframer.
// Holds Q_DEPTH words of type t_entry. Uses lrd_pkg.
`default_nettype none
module lrd_queue import lrd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output      t_entry o_head,
    output      logic   o_empty,
    output      logic   o_full
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lrd_back.sv
// Back of the deframer: expands each queue word into one or two results
// on the output channel. Uses lrd_pkg and lrd_out_if.
`default_nettype none
module lrd_back import lrd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output      logic   o_pop,
    lrd_out_if.source   o_out
);

    logic r_second;
    logic take;

    assign take  = o_out.valid && o_out.ready;
    assign o_pop = take && (r_second || !i_head.two);

    always_comb begin
        o_out.valid        = !i_empty;
        o_out.deletion     = i_head.deletion;
        o_out.key_length   = i_head.key_length;
        o_out.value_length = i_head.value_length;
        if (r_second) begin
            o_out.out_byte = 8'd0;
            o_out.out_kind = KIND_VERDICT;
            o_out.verdict  = i_head.second_verdict;
            o_out.last     = 1'b1;
        end else begin
            o_out.out_byte = i_head.data;
            o_out.out_kind = i_head.kind;
            o_out.verdict  = i_head.verdict;
            o_out.last     = !i_head.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !r_second && i_head.two;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/log_record_deframer_crc32c.sv
// Top level of the log record deframer with CRC32C check.
// Instantiates lrd_front, lrd_queue and lrd_back; uses lrd_pkg and lrd_if.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  i_in     | in  | valid/ready        | data_byte[7:0], end_of_file
//  o_out    | out | valid/ready        | out_byte, out_kind, verdict, deletion,
//           |     |                    | key_length, value_length, last
//  cfg      | in  | i_cfg_we           | i_cfg_wdata[31:0] (delete marker)
//
// One byte accepted per cycle; ready drops only while the 4-word queue is full.
// A last payload byte yields two results on the output channel: the byte, then its verdict.
// Each result is registered in the queue between acceptance and the output channel.
// Reset is synchronous, active low, and clears all control state.
// After a mismatch or end of stream, bytes are still taken and dropped.
`default_nettype none
module log_record_deframer_crc32c import lrd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lrd_in_if.sink           i_in,
    lrd_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    t_entry push_entry;
    t_entry head;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    logic   accept;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    lrd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_in.data_byte),
        .i_end_of_file (i_in.end_of_file),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    lrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    lrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: hw/rtl/lrd_checker.sv
// Port-level checks for the log record deframer, bound to the top level.
// Uses lrd_pkg and the lrd_if interfaces.
`default_nettype none
module lrd_checker import lrd_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lrd_in_if.sink    i_in,
    lrd_out_if.source o_out
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_full_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no pending result");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_kind == KIND_END) |->
        (o_out.last && !o_out.deletion && o_out.key_length == 32'd0
         && o_out.value_length == 32'd0))
        else $error("stream end result malformed");

    a_payload_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.out_kind == KIND_KEY || o_out.out_kind == KIND_VALUE))
        |-> (o_out.verdict == VERD_GOOD))
        else $error("payload result carries a verdict");

    a_byte_then_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=>
        (o_out.valid && o_out.out_kind == KIND_VERDICT && o_out.last))
        else $error("verdict does not follow last payload byte");

endmodule

bind log_record_deframer_crc32c lrd_checker u_lrd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
`default_nettype wire

// File: sim/log_record_deframer_crc32c_tb.sv
// Testbench for log_record_deframer_crc32c: frames log records byte by byte and
// checks every result word against a predictor of the deframer and its CRC32C.
// Depends on lrd_pkg, lrd_if and the RTL of the block.
module log_record_deframer_crc32c_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrd_pkg::*;

    typedef enum logic [1:0] {PH_HEADER = 2'b01, PH_PAYLOAD = 2'b10} t_phase;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic [1:0]  verdict;
        logic        deletion;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] klen;
        logic [31:0] vword;
        logic [1:0]  fill;
        logic        wr;
        logic [7:0]  wr_at;
        logic [31:0] wr_val;
        logic        typed;
        logic [1:0]  verd;
    } t_row;

    localparam logic [1:0] FILL_RAND = 2'd0;
    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_ONES = 2'd2;
    localparam logic [1:0] FILL_ALT  = 2'd3;

    localparam int TAIL_CLEAN       = 0;
    localparam int TAIL_CUT_HEADER  = 1;
    localparam int TAIL_CUT_PAYLOAD = 2;
    localparam int TAIL_BAD_CRC     = 3;

    localparam int          RANDOM_WORDS = 1260;
    localparam int          SETTLE       = 6;
    localparam int          MAX_PRINTS   = 40;
    localparam logic [31:0] NO_CAP       = 32'hFFFF_FFFF;

    // klen, value word, fill, write, write position, write value, typed, verdict
    localparam t_row PLAN [8] = '{
        '{32'd0, 32'd0,           FILL_RAND, 1'b0, 8'd0,  32'd0,           1'b1, VERD_GOOD},
        '{32'd1, 32'd0,           FILL_ZERO, 1'b0, 8'd0,  32'd0,           1'b0, VERD_GOOD},
        '{32'd0, 32'd1,           FILL_ONES, 1'b0, 8'd0,  32'd0,           1'b0, VERD_GOOD},
        '{32'd3, 32'hFFFF_FFFF,   FILL_ALT,  1'b0, 8'd0,  32'd0,           1'b1, VERD_GOOD},
        '{32'd2, 32'd3,           FILL_RAND, 1'b1, 8'd13, 32'd0,           1'b0, VERD_GOOD},
        '{32'd2, 32'd0,           FILL_ONES, 1'b0, 8'd0,  32'd0,           1'b1, VERD_GOOD},
        '{32'd1, 32'd5,           FILL_ZERO, 1'b1, 8'd6,  32'd5,           1'b0, VERD_GOOD},
        '{32'd0, 32'd0,           FILL_RAND, 1'b1, 8'd0,  32'hFFFF_FFFF,   1'b1, VERD_GOOD}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    lrd_in_if  in_bus();
    lrd_out_if out_bus();

    log_record_deframer_crc32c dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [31:0] marker;
    t_phase      ph;
    logic [3:0]  hdr_cnt;
    logic [31:0] stored;
    logic [31:0] klen_p;
    logic [31:0] vlen_p;
    logic [31:0] crc_p;
    logic [32:0] left;
    logic        del_p;
    logic        halted_p;

    t_result    due_results[$];
    logic [7:0] framed[$];
    bit         typed_on   = 1'b0;
    logic [1:0] typed_verd = VERD_GOOD;
    bit         gaps_on    = 1'b1;
    int         errors     = 0;
    int         words_sent = 0;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC32C_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void open_record();
        ph      = PH_HEADER;
        hdr_cnt = '0;
        stored  = '0;
        klen_p  = '0;
        vlen_p  = '0;
        left    = '0;
        crc_p   = CRC_INIT;
        del_p   = 1'b0;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic [1:0] kind,
                                        input logic [1:0] verd, input logic rec,
                                        input logic last);
        t_result r;
        r.out_byte     = b;
        r.kind         = kind;
        r.verdict      = verd;
        r.deletion     = rec & del_p;
        r.key_length   = rec ? klen_p : 32'd0;
        r.value_length = rec ? vlen_p : 32'd0;
        r.last         = last;
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void close_record();
        logic good;
        good = ((crc_p ^ CRC_INIT) == stored);
        push_result(8'd0, KIND_VERDICT,
                    typed_on ? typed_verd : (good ? VERD_GOOD : VERD_MISMATCH), 1'b1, 1'b1);
        if (good) open_record();
        else halted_p = 1'b1;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic eof);
        logic [1:0] kind;
        if (halted_p) return;
        if (eof) begin
            push_result(8'd0, KIND_END, typed_on ? typed_verd :
                        ((ph == PH_HEADER && hdr_cnt == 0) ? VERD_CLEAN : VERD_TRUNC),
                        1'b0, 1'b1);
            halted_p = 1'b1;
            return;
        end
        if (ph == PH_HEADER) begin
            if (hdr_cnt < 4) begin
                stored[8*hdr_cnt[1:0] +: 8] = b;
            end else begin
                crc_p = crc32c_byte(crc_p, b);
                if (hdr_cnt < 8) klen_p[8*hdr_cnt[1:0] +: 8] = b;
                else vlen_p[8*hdr_cnt[1:0] +: 8] = b;
            end
            hdr_cnt++;
            if (hdr_cnt == HEADER_BYTES) begin
                del_p = (vlen_p == marker);
                if (del_p) vlen_p = '0;
                left = {1'b0, klen_p} + {1'b0, vlen_p};
                ph   = PH_PAYLOAD;
                if (left == 0) close_record();
            end
            return;
        end
        kind  = (left > {1'b0, vlen_p}) ? KIND_KEY : KIND_VALUE;
        crc_p = crc32c_byte(crc_p, b);
        left--;
        if (left != 0) begin
            push_result(b, kind, VERD_GOOD, 1'b1, 1'b1);
        end else begin
            push_result(b, kind, VERD_GOOD, 1'b1, 1'b0);
            close_record();
        end
    endfunction

    // Build header and payload into framed; payload is cut at cap bytes.
    function automatic void frame_record(input logic [31:0] klen, input logic [31:0] vword,
                                         input logic [31:0] mark, input logic [1:0] fill,
                                         input logic [31:0] flip, input int unsigned cap);
        logic [7:0]  body[$];
        logic [32:0] total;
        logic [31:0] crc;
        logic [7:0]  b;
        total = {1'b0, klen} + ((vword == mark) ? 33'd0 : {1'b0, vword});
        if (total > cap) total = 33'(cap);
        crc = CRC_INIT;
        for (int i = 0; i < 4; i++) crc = crc32c_byte(crc, klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) crc = crc32c_byte(crc, vword[8*i +: 8]);
        for (int unsigned j = 0; j < total; j++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_ALT:  b = j[0] ? 8'hAA : 8'h55;
                default:   b = 8'($urandom_range(255));
            endcase
            crc = crc32c_byte(crc, b);
            body.insert(body.size(), b);
        end
        crc = crc ^ CRC_INIT ^ flip;
        framed.delete();
        for (int i = 0; i < 4; i++) framed.insert(framed.size(), crc[8*i +: 8]);
        for (int i = 0; i < 4; i++) framed.insert(framed.size(), klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) framed.insert(framed.size(), vword[8*i +: 8]);
        foreach (body[i]) framed.insert(framed.size(), body[i]);
    endfunction

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic send_word(input logic [7:0] b, input logic eof);
        while (gaps_on && $urandom_range(99) < 9) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       = 1'b1;
        in_bus.data_byte   = b;
        in_bus.end_of_file = eof;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predict_word(b, eof);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_marker(input logic [31:0] v);
        in_bus.valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        marker   = v;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_bus.ready = !(gaps_on && $urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                report_error($sformatf("unexpected word, kind %0d", out_bus.out_kind));
            end else begin
                want = due_results.pop_front();
                check_field("out_byte", 32'(out_bus.out_byte), 32'(want.out_byte));
                check_field("out_kind", 32'(out_bus.out_kind), 32'(want.kind));
                check_field("verdict", 32'(out_bus.verdict), 32'(want.verdict));
                check_field("deletion", 32'(out_bus.deletion), 32'(want.deletion));
                check_field("key_length", out_bus.key_length, want.key_length);
                check_field("value_length", out_bus.value_length, want.value_length);
                check_field("last", 32'(out_bus.last), 32'(want.last));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_row        row;
        logic [31:0] mark;
        logic [31:0] klen;
        logic [31:0] vword;
        int unsigned cut;
        int unsigned tail;
        int          rand_start;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_bus.valid       = 1'b0;
        in_bus.data_byte   = '0;
        in_bus.end_of_file = 1'b0;
        marker             = MARKER_RESET;
        halted_p           = 1'b0;
        open_record();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < 8; r++) begin
            row  = PLAN[r];
            mark = (row.wr && row.wr_at < HEADER_BYTES) ? row.wr_val : marker;
            frame_record(row.klen, row.vword, mark, row.fill, 32'd0, NO_CAP);
            typed_on   = row.typed;
            typed_verd = row.verd;
            foreach (framed[i]) begin
                if (row.wr && i == row.wr_at) load_marker(row.wr_val);
                send_word(framed[i], 1'b0);
            end
            typed_on = 1'b0;
        end

        rand_start = words_sent;
        while (words_sent - rand_start < RANDOM_WORDS) begin
            gaps_on = !(words_sent - rand_start >= 400 && words_sent - rand_start < 750);
            if ($urandom_range(99) < 6) begin
                case ($urandom_range(3))
                    0:       load_marker(32'd0);
                    1:       load_marker(32'hFFFF_FFFF);
                    2:       load_marker($urandom_range(12));
                    default: load_marker($urandom);
                endcase
            end
            klen  = ($urandom_range(99) < 75) ? $urandom_range(8) : $urandom_range(40);
            vword = ($urandom_range(99) < 15) ? marker :
                    (($urandom_range(99) < 75) ? $urandom_range(8) : $urandom_range(40));
            frame_record(klen, vword, marker, FILL_RAND, 32'd0, NO_CAP);
            foreach (framed[i]) send_word(framed[i], 1'b0);
        end
        gaps_on = 1'b1;

        // One halting event per run; pick which.
        tail = $urandom_range(3);
        case (tail)
            TAIL_CLEAN: begin
                typed_on   = 1'b1;
                typed_verd = VERD_CLEAN;
                send_word(8'($urandom), 1'b1);
            end
            TAIL_CUT_HEADER: begin
                frame_record($urandom_range(8), $urandom_range(8), marker, FILL_RAND,
                             32'd0, NO_CAP);
                cut = $urandom_range(HEADER_BYTES - 1, 1);
                for (int i = 0; i < cut; i++) send_word(framed[i], 1'b0);
                typed_on   = 1'b1;
                typed_verd = VERD_TRUNC;
                send_word(8'($urandom), 1'b1);
            end
            TAIL_CUT_PAYLOAD: begin
                klen  = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
                vword = $urandom_range(1) ? 32'hFFFF_FFFE : $urandom;
                cut   = $urandom_range(20, 1);
                frame_record(klen, vword, marker, FILL_RAND, 32'd0, cut);
                foreach (framed[i]) send_word(framed[i], 1'b0);
                send_word(8'($urandom), 1'b1);
            end
            default: begin
                frame_record($urandom_range(8), $urandom_range(8), marker, FILL_RAND,
                             32'd1 << $urandom_range(31), NO_CAP);
                typed_on   = 1'b1;
                typed_verd = VERD_MISMATCH;
                foreach (framed[i]) send_word(framed[i], 1'b0);
            end
        endcase
        typed_on = 1'b0;

        // Halted: drop everything.
        repeat (16) send_word(8'($urandom), $urandom_range(3) == 0);

        in_bus.valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_if.sv
hw/rtl/lrd_front.sv
hw/rtl/lrd_queue.sv
hw/rtl/lrd_back.sv
hw/rtl/log_record_deframer_crc32c.sv
hw/rtl/lrd_checker.sv
sim/log_record_deframer_crc32c_tb.sv
